/* rtl/psle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psle_pkg
// Types, scan codes and keymap tables for the scancode line editor.
// ----------------------------------------------------------------------------
package psle_pkg;

  localparam logic [7:0] CODE_CAPS        = 8'h3A;
  localparam logic [7:0] CODE_SHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] CODE_SHIFT_BREAK = 8'hAA;
  localparam logic [7:0] CODE_ENTER       = 8'h1C;
  localparam logic [7:0] CODE_BACKSPACE   = 8'h0E;
  localparam logic [7:0] CODE_RELEASE     = 8'h80;
  localparam logic [7:0] MAP_SIZE         = 8'd58;

  localparam int MAP_ENTRIES = 64;

  typedef enum logic [1:0] {
    KIND_ECHO      = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_LINE      = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // set-1 make codes to ascii, entries past the keymap read as '?'
  localparam logic [6:0] MAP_LOWER [MAP_ENTRIES] = '{
    7'h3F, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h3F, 7'h3F,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h3F, 7'h3F, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h3F, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F,
    7'h3F, 7'h20, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F
  };

  localparam logic [6:0] MAP_UPPER [MAP_ENTRIES] = '{
    7'h3F, 7'h3F, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
    7'h2F, 7'h28, 7'h29, 7'h3D, 7'h2D, 7'h3D, 7'h3F, 7'h3F,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h3F, 7'h3F, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
    7'h27, 7'h60, 7'h3F, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F,
    7'h3F, 7'h20, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F
  };

endpackage

/* rtl/ps2_scancode_line_editor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_line_editor
// Set-1 scancode to ascii line editor with echo and line readout on enter.
// ----------------------------------------------------------------------------
// A keystroke result is registered in the cycle after its transfer.
// Throughput: one keystroke per cycle while the result register drains.
// Enter reads the line store one character per cycle while results are taken
// (registered read, prefetched).
// Reset: synchronous active-low rst_n clears case flag, fill count and control;
// the line store itself is not cleared, only entries below the fill are read.
module ps2_scancode_line_editor
  import psle_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [6:0] out_character,
  output logic       out_last
);

  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int FILL_W = $clog2(LINE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINE_DEPTH);

  logic [6:0] mem [LINE_DEPTH];

  state_t            state_r, state_nxt;
  logic              upper_r, upper_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [6:0]        rd_data_r;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [6:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [6:0]        mem_wdata;

  logic              slot_free, accept, consume, issue;
  logic [6:0]        map_ch;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign map_ch    = upper_r ? MAP_UPPER[in_scan_code[5:0]] : MAP_LOWER[in_scan_code[5:0]];

  always_comb begin
    state_nxt     = state_r;
    upper_nxt     = upper_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[ADDR_W-1:0];
    mem_wdata     = map_ch;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_r[ADDR_W-1:0];
    consume       = 1'b0;
    issue         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_scan_code)
            CODE_CAPS:        upper_nxt = !upper_r;
            CODE_SHIFT_MAKE:  upper_nxt = 1'b1;
            CODE_SHIFT_BREAK: upper_nxt = 1'b0;
            CODE_BACKSPACE: begin
              if (fill_r != '0) begin
                fill_nxt      = fill_r - FILL_W'(1);
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_BACKSPACE;
                out_char_nxt  = '0;
                out_last_nxt  = 1'b1;
              end
            end
            CODE_ENTER: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_EMPTY;
                out_char_nxt  = '0;
                out_last_nxt  = 1'b1;
              end else begin
                state_nxt  = ST_READ;
                rd_idx_nxt = '0;
                pend_nxt   = 1'b0;
              end
            end
            default: begin
              // release codes and codes past the keymap give nothing
              if ((in_scan_code & CODE_RELEASE) == '0 && in_scan_code < MAP_SIZE &&
                  fill_r != FILL_FULL) begin
                mem_we        = 1'b1;
                fill_nxt      = fill_r + FILL_W'(1);
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_ECHO;
                out_char_nxt  = map_ch;
                out_last_nxt  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        consume = pend_r && slot_free;
        issue   = (rd_idx_r < fill_r) && (!pend_r || consume);
        if (consume) begin
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LINE;
          out_char_nxt  = rd_data_r;
          out_last_nxt  = rd_last_r;
          if (rd_last_r) begin
            state_nxt = ST_IDLE;
            fill_nxt  = '0;
          end
        end
        if (issue) begin
          // prefetch next stored character so readout keeps one per cycle while results are taken
          mem_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + FILL_W'(1);
          rd_last_nxt = (rd_idx_r + FILL_W'(1)) == fill_r;
          pend_nxt    = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upper_r     <= 1'b0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upper_r     <= upper_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    rd_last_r  <= rd_last_nxt;
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* bench/tb_ps2_scancode_line_editor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_scancode_line_editor
// Self-checking bench for the set-1 scancode line editor: keystrokes go in
// through a valid/ready channel, a keystroke-level line model predicts echoes,
// backspaces, empty lines and line readouts, and every result transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_ps2_scancode_line_editor;
  import psle_pkg::*;

  localparam int LINE_DEPTH = 64;
  localparam int KEY_TARGET = 370;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] ch;
    logic       last;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_code = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [6:0] out_character;
  logic       out_last;

  // keymaps for the line model, indexed by make code
  string keys_lower = "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./??? ";
  string keys_upper = "??!\"#$%&/()=-=??QWERTYUIOP[]??ASDFGHJKL;'`?\\ZXCVBNM,./??? ";

  // line model state
  logic         shift_lock;
  logic [6:0]   typed_line [LINE_DEPTH];
  int unsigned  typed_len;

  line_result_t pending_results [$];
  line_result_t got_result;
  int           out_hold;
  bit           gaps_on;
  int           mismatches;
  int           keys_effective;
  int           n_sent;
  int           n_echo, n_backspace, n_lines, n_empty, n_dropped, n_results, longest_line;

  ps2_scancode_line_editor #(.LINE_DEPTH(LINE_DEPTH)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_code (in_scan_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  function automatic line_result_t make_result(kind_t k, logic [6:0] c, logic l);
    line_result_t r;
    r.kind = k;
    r.ch   = c;
    r.last = l;
    return r;
  endfunction

  function automatic logic [7:0] rand_char_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, int'(MAP_SIZE) - 1));
    end while (c == CODE_ENTER || c == CODE_BACKSPACE || c == CODE_SHIFT_MAKE);
    return c;
  endfunction

  // advance the line model by one accepted keystroke
  task automatic apply_key(input logic [7:0] code);
    logic [6:0] c;
    begin
      if (code == CODE_CAPS) begin
        shift_lock = ~shift_lock;
        keys_effective++;
      end else if (code == CODE_SHIFT_MAKE) begin
        shift_lock = 1'b1;
        keys_effective++;
      end else if (code == CODE_SHIFT_BREAK) begin
        shift_lock = 1'b0;
        keys_effective++;
      end else if (code == CODE_BACKSPACE) begin
        if (typed_len != 0) begin
          typed_len--;
          typed_line[typed_len] = 7'h20;
          pending_results.push_back(make_result(KIND_BACKSPACE, 7'h00, 1'b1));
          n_backspace++;
          keys_effective++;
        end
      end else if (code == CODE_ENTER) begin
        if (typed_len == 0) begin
          pending_results.push_back(make_result(KIND_EMPTY, 7'h00, 1'b1));
          n_empty++;
        end else begin
          for (int i = 0; i < typed_len; i++)
            pending_results.push_back(make_result(KIND_LINE, typed_line[i],
                                                  (i + 1 == typed_len)));
          n_lines++;
          if (typed_len > longest_line) longest_line = typed_len;
        end
        typed_len = 0;
        keys_effective++;
      end else if ((code & CODE_RELEASE) == 0 && code < MAP_SIZE) begin
        if (typed_len >= LINE_DEPTH) begin
          // line full, keystroke is lost without echo
          n_dropped++;
        end else begin
          c = shift_lock ? 7'(keys_upper[code]) : 7'(keys_lower[code]);
          typed_line[typed_len] = c;
          typed_len++;
          pending_results.push_back(make_result(KIND_ECHO, c, 1'b1));
          n_echo++;
          keys_effective++;
        end
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    begin
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // input and result transfers, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) apply_key(in_scan_code);
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0d char %02h last %0d",
                                  out_kind, out_character, out_last));
        end else begin
          got_result = pending_results.pop_front();
          if (out_kind !== got_result.kind || out_character !== got_result.ch ||
              out_last !== got_result.last)
            note_mismatch($sformatf(
              "expected kind %0d char %02h last %0d, got kind %0d char %02h last %0d",
              got_result.kind, got_result.ch, got_result.last,
              out_kind, out_character, out_last));
        end
        out_hold = gaps_on ? $urandom_range(0, 14) : 0;
      end
    end
  end

  // result side backpressure: with gaps on, ready may drop for a randomly drawn hold after each transfer
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= (out_hold == 0);
      if (out_hold > 0) out_hold--;
    end
  end

  task automatic send_key(input logic [7:0] code);
    int gap;
    begin
      gap = gaps_on ? $urandom_range(0, 14) : 0;
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_scan_code <= code;
      do @(posedge clk); while (!in_ready);
      n_sent++;
    end
  endtask

  task automatic test_empty_line();
    begin
      send_key(CODE_ENTER);
      send_key(CODE_BACKSPACE);
      send_key(CODE_ENTER);
    end
  endtask

  task automatic test_case_mapping();
    begin
      send_key(8'h10);
      send_key(8'h00);
      send_key(8'h39);
      send_key(8'h02);
      send_key(CODE_CAPS);
      send_key(8'h02);
      send_key(8'h1E);
      send_key(CODE_CAPS);
      send_key(CODE_SHIFT_MAKE);
      send_key(8'h08);
      send_key(CODE_SHIFT_BREAK);
      send_key(8'h08);
      send_key(CODE_ENTER);
    end
  endtask

  task automatic test_backspace();
    begin
      send_key(8'h2C);
      send_key(8'h2D);
      send_key(CODE_BACKSPACE);
      send_key(CODE_BACKSPACE);
      send_key(CODE_BACKSPACE);
      send_key(8'h0B);
      send_key(CODE_ENTER);
    end
  endtask

  task automatic test_ignored_codes();
    begin
      send_key(8'h3B);
      send_key(8'h7F);
      send_key(CODE_RELEASE);
      send_key(8'hFF);
      send_key(CODE_ENTER | CODE_RELEASE);
      send_key(CODE_ENTER);
    end
  endtask

  task automatic test_line_full();
    begin
      repeat (LINE_DEPTH + 3) send_key(rand_char_code());
      send_key(CODE_BACKSPACE);
      send_key(rand_char_code());
      send_key(rand_char_code());
      send_key(CODE_ENTER);
    end
  endtask

  // mostly typed lines with edits, some noise and some lines left unfinished
  task automatic test_random_typing();
    int mode, len;
    logic [7:0] k;
    begin
      while (n_sent < KEY_TARGET) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        mode = $urandom_range(0, 9);
        if (mode <= 6) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
          repeat (len) begin
            case ($urandom_range(0, 15))
              0: send_key(CODE_CAPS);
              1: send_key(CODE_SHIFT_MAKE);
              2: send_key(CODE_SHIFT_BREAK);
              3: send_key(CODE_BACKSPACE);
              default: begin
                k = rand_char_code();
                send_key(k);
                if ($urandom_range(0, 2) == 0) send_key(k | CODE_RELEASE);
              end
            endcase
          end
          send_key(CODE_ENTER);
        end else if (mode <= 8) begin
          repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(0, 4)) send_key(rand_char_code());
          repeat ($urandom_range(1, 7)) send_key(CODE_BACKSPACE);
        end
      end
    end
  endtask

  initial begin
    shift_lock     = 1'b0;
    typed_len      = 0;
    out_hold       = 0;
    gaps_on        = 1'b1;
    mismatches     = 0;
    keys_effective = 0;
    n_sent         = 0;
    n_echo = 0; n_backspace = 0; n_lines = 0; n_empty = 0;
    n_dropped = 0; n_results = 0; longest_line = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_line();
    test_case_mapping();
    test_backspace();
    test_ignored_codes();
    test_line_full();
    test_random_typing();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d keystrokes (%0d with an effect), %0d results: %0d echoes, %0d backspaces",
             n_sent, keys_effective, n_results, n_echo, n_backspace);
    $display("%0d lines read out (longest %0d), %0d empty lines, %0d keys lost to a full line",
             n_lines, longest_line, n_empty, n_dropped);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
